// ===== src/delimiter_tokenizer_with_decimal_value_defines.svh =====
// Assertion macros shared by the delimiter tokenizer RTL.
`ifndef DELIMITER_TOKENIZER_WITH_DECIMAL_VALUE_DEFINES_SVH
`define DELIMITER_TOKENIZER_WITH_DECIMAL_VALUE_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define DTK_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define DTK_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/dtk_pkg.sv =====
// Types and constants of the delimiter tokenizer.
package dtk_pkg;

	localparam int unsigned NUM_DELIM_REGS = 5;

	// Input kinds.
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Configuration register indexes.
	localparam logic [2:0] REG_DELIM_A    = 3'd0;
	localparam logic [2:0] REG_DELIM_B    = 3'd1;
	localparam logic [2:0] REG_DELIM_C    = 3'd2;
	localparam logic [2:0] REG_DELIM_D    = 3'd3;
	localparam logic [2:0] REG_DELIM_E    = 3'd4;
	localparam logic [2:0] REG_DELIM_USED = 3'd5;

	// Reset values of the configuration registers.
	localparam logic [7:0] DELIM_A_RST    = 8'h0A;
	localparam logic [7:0] DELIM_B_RST    = 8'h2C;
	localparam logic [7:0] DELIM_C_RST    = 8'h3D;
	localparam logic [7:0] DELIM_D_RST    = 8'h28;
	localparam logic [7:0] DELIM_E_RST    = 8'h29;
	localparam logic [2:0] DELIM_USED_RST = 3'd5;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	typedef struct packed {
		logic       kind;
		logic [7:0] char_in;
	} in_t;

	typedef struct packed {
		logic        token_valid;
		logic [7:0]  token_index;
		logic [15:0] token_begin;
		logic [15:0] token_length;
		logic [31:0] token_value;
		logic        is_end;
		logic [8:0]  token_count;
		logic        overflow;
	} out_t;

endpackage

// ===== src/delimiter_tokenizer_with_decimal_value.sv =====
// Top level of the delimiter tokenizer with decimal token value. A string enters one
// byte per input beat (kind = byte), closed by one beat with kind = end. Bytes equal
// to one of the first delim_used delimiter registers (at most MAX_DELIMS) end the
// open token; runs of delimiters produce nothing. Each closed token within TOK_LIMIT
// leaves as one output beat with its index, start, length and decimal digit value.
// The end beat always yields one output beat with is_end set, the token count and
// overflow flag, carrying the flushed token if one was open and fit, and clears the
// string state. Both channels are valid/stall. One byte is taken every cycle unless
// in_stall is high: the next-state logic is a short compare, add and shift-add path
// between the state registers and the output stage. The output side holds a result
// register plus one skid register, so an input beat is still taken while a finished
// result waits; in_stall rises only when both are full. Stalled output beats hold
// their payload. Reset clears the string state and both output valid flags and loads
// the default delimiters (newline, comma, equals, open and close parenthesis, all
// five active). Configuration writes through cfg_we/cfg_index/cfg_data take effect
// at once; the user must do them only while idle, which the block does not enforce.
`include "delimiter_tokenizer_with_decimal_value_defines.svh"

module delimiter_tokenizer_with_decimal_value
	import dtk_pkg::*;
#(
	parameter int unsigned MAX_TOKENS = 256,
	parameter int unsigned MAX_LENGTH = 65535,
	parameter int unsigned MAX_DELIMS = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_t        in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_t       out_data,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	// The token counter is nine bits wide, so the limit is capped at 511.
	localparam logic [8:0]  TOK_LIMIT = 9'((MAX_TOKENS > 511) ? 511 : MAX_TOKENS);
	localparam logic [15:0] LEN_LIMIT = 16'(MAX_LENGTH);
	localparam logic [2:0]  DELIM_CAP = 3'((MAX_DELIMS > NUM_DELIM_REGS) ?
		NUM_DELIM_REGS : MAX_DELIMS);

	// Configuration registers.
	logic [7:0] delim_q [NUM_DELIM_REGS];
	logic [2:0] delim_used_q;

	// String state.
	logic        in_token_q;
	logic [15:0] start_pos_q;
	logic [15:0] byte_pos_q;
	logic [8:0]  tokens_found_q;
	logic [31:0] value_acc_q;
	logic        overflow_seen_q;

	// Output stage: result register and skid register.
	logic out_valid_q;
	logic skid_valid_q;
	out_t out_q;
	out_t skid_q;

	// Next-state and result of the current beat.
	logic        in_token_d;
	logic [15:0] start_pos_d;
	logic [15:0] byte_pos_d;
	logic [8:0]  tokens_found_d;
	logic [31:0] value_acc_d;
	logic        overflow_seen_d;
	out_t        res;
	logic        push;

	logic        in_acc;
	logic        out_pop;
	logic [2:0]  delim_active;
	logic        is_delim;
	logic        is_digit;
	logic        room;
	logic [31:0] value_base;
	out_t        token_res;

	assign in_stall  = skid_valid_q;
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_pop   = out_valid_q && !out_stall;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q[0]   <= DELIM_A_RST;
			delim_q[1]   <= DELIM_B_RST;
			delim_q[2]   <= DELIM_C_RST;
			delim_q[3]   <= DELIM_D_RST;
			delim_q[4]   <= DELIM_E_RST;
			delim_used_q <= DELIM_USED_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DELIM_A:    delim_q[0]   <= cfg_data;
				REG_DELIM_B:    delim_q[1]   <= cfg_data;
				REG_DELIM_C:    delim_q[2]   <= cfg_data;
				REG_DELIM_D:    delim_q[3]   <= cfg_data;
				REG_DELIM_E:    delim_q[4]   <= cfg_data;
				REG_DELIM_USED: delim_used_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// All five comparators run in parallel; only the first delim_active count.
	always_comb begin
		delim_active = (delim_used_q > DELIM_CAP) ? DELIM_CAP : delim_used_q;
		is_delim = 1'b0;
		for (int i = 0; i < NUM_DELIM_REGS; i++) begin
			if ((3'(i) < delim_active) && (delim_q[i] == in_data.char_in)) begin
				is_delim = 1'b1;
			end
		end
	end

	assign is_digit = (in_data.char_in >= CHAR_ZERO) && (in_data.char_in <= CHAR_NINE);
	assign room     = tokens_found_q < TOK_LIMIT;

	// A fresh token starts its value from zero.
	assign value_base = in_token_q ? value_acc_q : 32'd0;

	// Fields of the token that closes on this beat.
	always_comb begin
		token_res              = '0;
		token_res.token_valid  = 1'b1;
		token_res.token_index  = tokens_found_q[7:0];
		token_res.token_begin  = start_pos_q;
		token_res.token_length = byte_pos_q - start_pos_q;
		token_res.token_value  = value_acc_q;
	end

	always_comb begin
		in_token_d      = in_token_q;
		start_pos_d     = start_pos_q;
		byte_pos_d      = byte_pos_q;
		tokens_found_d  = tokens_found_q;
		value_acc_d     = value_acc_q;
		overflow_seen_d = overflow_seen_q;
		res             = '0;
		push            = 1'b0;

		if (in_data.kind == KIND_END) begin
			// Flush the open token if there is room, report and clear the string.
			push = 1'b1;
			if (in_token_q && room) begin
				res = token_res;
			end
			res.is_end      = 1'b1;
			res.token_count = tokens_found_q + 9'(in_token_q && room);
			res.overflow    = overflow_seen_q || (in_token_q && !room);
			in_token_d      = 1'b0;
			start_pos_d     = '0;
			byte_pos_d      = '0;
			tokens_found_d  = '0;
			value_acc_d     = '0;
			overflow_seen_d = 1'b0;
		end else if (byte_pos_q >= LEN_LIMIT) begin
			// Bytes past the length limit are dropped.
			overflow_seen_d = 1'b1;
		end else begin
			byte_pos_d = byte_pos_q + 16'd1;
			if (is_delim) begin
				if (in_token_q) begin
					in_token_d = 1'b0;
					if (room) begin
						push           = 1'b1;
						res            = token_res;
						res.overflow   = overflow_seen_q;
						tokens_found_d = tokens_found_q + 9'd1;
					end else begin
						overflow_seen_d = 1'b1;
					end
				end
			end else begin
				if (!in_token_q) begin
					in_token_d  = 1'b1;
					start_pos_d = byte_pos_q;
				end
				// value * 10 + digit as two shifts and two adds, wrapping at 32 bits.
				if (is_digit) begin
					value_acc_d = (value_base << 3) + (value_base << 1) +
						{24'd0, in_data.char_in - CHAR_ZERO};
				end else begin
					value_acc_d = value_base;
				end
			end
		end
	end

	// String state advances on every accepted input beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_token_q      <= 1'b0;
			start_pos_q     <= '0;
			byte_pos_q      <= '0;
			tokens_found_q  <= '0;
			value_acc_q     <= '0;
			overflow_seen_q <= 1'b0;
		end else if (in_acc) begin
			in_token_q      <= in_token_d;
			start_pos_q     <= start_pos_d;
			byte_pos_q      <= byte_pos_d;
			tokens_found_q  <= tokens_found_d;
			value_acc_q     <= value_acc_d;
			overflow_seen_q <= overflow_seen_d;
		end
	end

	// Output stage control. The skid register fills only when the result
	// register is held by a stall; it drains into the result register first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_acc && push;
			end
		end else if (in_acc && push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Output stage payload.
	always_ff @(posedge clk) begin
		if (!out_valid_q || out_pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_acc && push) begin
				out_q <= res;
			end
		end else if (in_acc && push) begin
			skid_q <= res;
		end
	end

	`DTK_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid full with result register empty")
	`DTK_ASSERT(a_end_gives_beat, (in_acc && in_data.kind == KIND_END) |=> out_valid_q, "end beat produced no result")
	`DTK_ASSERT(a_count_in_limit, tokens_found_q <= TOK_LIMIT, "token count beyond limit")

endmodule
